// ----- rtl/core/uart_tx_rx_ring_buffers_unit_macros.svh -----
// ---------------------------------------------------------------------------
// uart ring buffer assertion macros
// concurrent checks clocked on clk, held off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef UART_TX_RX_RING_BUFFERS_UNIT_MACROS_SVH
`define UART_TX_RX_RING_BUFFERS_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define URTB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define URTB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/urtb_pkg.sv -----
// ---------------------------------------------------------------------------
// urtb_pkg
// shared types and constants of the uart transmit and receive ring buffers
// ---------------------------------------------------------------------------
package urtb_pkg;

    localparam int SEND_DEPTH = 32;
    localparam int RECV_DEPTH = 32;

    localparam int SEND_PW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
    localparam int RECV_PW = (RECV_DEPTH > 1) ? $clog2(RECV_DEPTH) : 1;
    localparam int SEND_FW = $clog2(SEND_DEPTH + 1);
    localparam int RECV_FW = $clog2(RECV_DEPTH + 1);

    localparam int COUNT_W  = 6;
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_TX_DONE = 2'd2,
        CMD_RX_BYTE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic take;
        logic load;
    } ctrl_cmd_t;

    // lowest field last so that accepted sits in bit 0
    typedef struct packed {
        logic               overrun;
        logic [7:0]         line_byte;
        logic               line_write;
        logic [COUNT_W-1:0] read_count;
        logic [7:0]         read_byte;
        logic               accepted;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ----- rtl/core/urtb_ctrl.sv -----
// ---------------------------------------------------------------------------
// urtb_ctrl
// sequencer: takes one word, steps the datapath, holds the result until taken
// ---------------------------------------------------------------------------
module urtb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output urtb_pkg::ctrl_cmd_t  cmd
);
    import urtb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign cmd.take  = in_valid && (state_reg == ST_IDLE);
    assign cmd.load  = (state_reg == ST_EXEC);

endmodule

// ----- rtl/core/urtb_dpath.sv -----
// ---------------------------------------------------------------------------
// urtb_dpath
// send and receive rings, line state, overrun flag and result register
// ---------------------------------------------------------------------------
`include "uart_tx_rx_ring_buffers_unit_macros.svh"

module urtb_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  urtb_pkg::ctrl_cmd_t cmd,
    input  logic [1:0]          in_cmd,
    input  logic [7:0]          in_data,
    output urtb_pkg::result_t   result
);
    import urtb_pkg::*;

    logic [7:0] send_mem [SEND_DEPTH];
    logic [7:0] recv_mem [RECV_DEPTH];

    logic [SEND_PW-1:0] send_head_reg, send_head_next;
    logic [SEND_PW-1:0] send_tail_reg, send_tail_next;
    logic [SEND_FW-1:0] send_fill_reg, send_fill_next;
    logic [RECV_PW-1:0] recv_head_reg, recv_head_next;
    logic [RECV_PW-1:0] recv_tail_reg, recv_tail_next;
    logic [RECV_FW-1:0] recv_fill_reg, recv_fill_next;
    logic               line_busy_reg, line_busy_next;
    logic               dropped_reg, dropped_next;

    logic               acc_reg, acc_next;
    logic               direct_reg, direct_next;
    logic               tx_hit_reg, tx_hit_next;
    logic               pop_hit_reg, pop_hit_next;
    logic [7:0]         byte_reg;
    logic [RECV_FW-1:0] count_reg;
    logic [7:0]         send_rd_reg;
    logic [7:0]         recv_rd_reg;
    result_t            result_reg;

    logic send_wr;
    logic recv_wr;
    cmd_t op;

    assign op = cmd_t'(in_cmd);

    always_comb
    begin
        send_head_next = send_head_reg;
        send_tail_next = send_tail_reg;
        send_fill_next = send_fill_reg;
        recv_head_next = recv_head_reg;
        recv_tail_next = recv_tail_reg;
        recv_fill_next = recv_fill_reg;
        line_busy_next = line_busy_reg;
        dropped_next   = dropped_reg;
        acc_next       = 1'b1;
        direct_next    = 1'b0;
        tx_hit_next    = 1'b0;
        pop_hit_next   = 1'b0;
        send_wr        = 1'b0;
        recv_wr        = 1'b0;
        if (cmd.take)
        begin
            unique case (op)
                CMD_PUSH:
                begin
                    if (!line_busy_reg)
                    begin
                        direct_next    = 1'b1;
                        line_busy_next = 1'b1;
                    end
                    else if (send_fill_reg >= SEND_FW'(SEND_DEPTH))
                    begin
                        acc_next = 1'b0;
                    end
                    else
                    begin
                        send_wr        = 1'b1;
                        send_tail_next = (send_tail_reg == SEND_PW'(SEND_DEPTH - 1)) ?
                                         '0 : send_tail_reg + 1'b1;
                        send_fill_next = send_fill_reg + 1'b1;
                    end
                end
                CMD_POP:
                begin
                    if (recv_fill_reg != '0)
                    begin
                        pop_hit_next   = 1'b1;
                        recv_head_next = (recv_head_reg == RECV_PW'(RECV_DEPTH - 1)) ?
                                         '0 : recv_head_reg + 1'b1;
                        recv_fill_next = recv_fill_reg - 1'b1;
                    end
                end
                CMD_TX_DONE:
                begin
                    if (send_fill_reg != '0)
                    begin
                        tx_hit_next    = 1'b1;
                        send_head_next = (send_head_reg == SEND_PW'(SEND_DEPTH - 1)) ?
                                         '0 : send_head_reg + 1'b1;
                        send_fill_next = send_fill_reg - 1'b1;
                    end
                    else
                    begin
                        line_busy_next = 1'b0;
                    end
                end
                CMD_RX_BYTE:
                begin
                    if (recv_fill_reg < RECV_FW'(RECV_DEPTH))
                    begin
                        recv_wr        = 1'b1;
                        recv_tail_next = (recv_tail_reg == RECV_PW'(RECV_DEPTH - 1)) ?
                                         '0 : recv_tail_reg + 1'b1;
                        recv_fill_next = recv_fill_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                default:
                begin
                    acc_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_head_reg <= '0;
            send_tail_reg <= '0;
            send_fill_reg <= '0;
            recv_head_reg <= '0;
            recv_tail_reg <= '0;
            recv_fill_reg <= '0;
            line_busy_reg <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            send_head_reg <= send_head_next;
            send_tail_reg <= send_tail_next;
            send_fill_reg <= send_fill_next;
            recv_head_reg <= recv_head_next;
            recv_tail_reg <= recv_tail_next;
            recv_fill_reg <= recv_fill_next;
            line_busy_reg <= line_busy_next;
            dropped_reg   <= dropped_next;
        end
    end

    // ring storage, registered read at the head
    always_ff @(posedge clk)
    begin
        if (send_wr)
        begin
            send_mem[send_tail_reg] <= in_data;
        end
        if (cmd.take)
        begin
            send_rd_reg <= send_mem[send_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (recv_wr)
        begin
            recv_mem[recv_tail_reg] <= in_data;
        end
        if (cmd.take)
        begin
            recv_rd_reg <= recv_mem[recv_head_reg];
        end
    end

    // per-word decision flags
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            acc_reg     <= acc_next;
            direct_reg  <= direct_next;
            tx_hit_reg  <= tx_hit_next;
            pop_hit_reg <= pop_hit_next;
            byte_reg    <= in_data;
            count_reg   <= recv_fill_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            result_reg.accepted   <= acc_reg;
            result_reg.read_byte  <= pop_hit_reg ? recv_rd_reg : 8'd0;
            result_reg.read_count <= pop_hit_reg ? COUNT_W'(count_reg) : '0;
            result_reg.line_write <= direct_reg | tx_hit_reg;
            result_reg.line_byte  <= direct_reg ? byte_reg :
                                     (tx_hit_reg ? send_rd_reg : 8'd0);
            result_reg.overrun    <= dropped_reg;
        end
    end

    assign result = result_reg;

    `URTB_ASSERT_NOW(a_send_fill_range, 1'b1, send_fill_reg <= SEND_FW'(SEND_DEPTH), "send fill beyond depth")
    `URTB_ASSERT_NOW(a_recv_fill_range, 1'b1, recv_fill_reg <= RECV_FW'(RECV_DEPTH), "recv fill beyond depth")
    `URTB_ASSERT_NOW(a_queue_needs_busy, send_fill_reg != '0, line_busy_reg, "send queue holds bytes while line idle")
    `URTB_ASSERT_NEXT(a_overrun_sticky, dropped_reg, dropped_reg, "overrun flag cleared")

endmodule

// ----- rtl/core/uart_tx_rx_ring_buffers_unit.sv -----
// ---------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_unit
// transmit and receive byte rings of an interrupt-driven serial port
// ---------------------------------------------------------------------------
// channel   dir  tuser      tdata
// s_axis    in   cmd[1:0]   data[7:0]
// m_axis    out  -          accepted, read_byte, read_count, line_write,
//                           line_byte, overrun
//
// each word is accepted with its ring read into the read register, then the
// result register is loaded; the next word is taken once the result is taken
// ring reads go through one registered read port per ring
// rst_n clears pointers, fill counts, line busy and overrun; ring contents
// are not cleared
// a stalled m_axis holds the result and keeps s_axis_tready low
// ---------------------------------------------------------------------------
module uart_tx_rx_ring_buffers_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [urtb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // data[7:0]
    input  logic [urtb_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // cmd[1:0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // accepted[0], read_byte[8:1], read_count[14:9], line_write[15],
    // line_byte[23:16], overrun[24], zeros above
    output logic [urtb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import urtb_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    result_t   result;

    urtb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (ctrl_cmd)
    );

    urtb_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ctrl_cmd),
        .in_cmd  (s_axis_tuser),
        .in_data (s_axis_tdata),
        .result  (result)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, result};

endmodule
